// File: hw/rtl/bucketed_hash_map_engine_unit_assert.svh
// Assertion macros for the bucketed hash map engine
`ifndef BUCKETED_HASH_MAP_ENGINE_UNIT_ASSERT_SVH
`define BUCKETED_HASH_MAP_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BHM_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bhm assertion failed");
`define BHM_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bhm assertion failed");
`else
`define BHM_ASSERT_NOW(name, pre, post)
`define BHM_ASSERT_NEXT(name, pre, post)
`endif
`endif

// File: hw/rtl/bhm_pkg.sv
// Package: types, sizes and codes of the bucketed hash map engine
`timescale 1ns / 1ps
package bhm_pkg;
    localparam int MAX_BUCKETS    = 256;
    localparam int SLOTS_PER_NODE = 4;
    localparam int POOL_NODES     = 256;
    localparam int NODE_TOTAL     = MAX_BUCKETS + POOL_NODES;
    localparam int SLOT_TOTAL     = NODE_TOTAL * SLOTS_PER_NODE;
    localparam int NODE_W         = $clog2(NODE_TOTAL);
    localparam int HEAD_W         = $clog2(MAX_BUCKETS);
    localparam int SLOT_W         = $clog2(SLOTS_PER_NODE);
    localparam int FILL_W         = SLOT_W + 1;
    localparam int SADDR_W        = NODE_W + SLOT_W;
    localparam int BC_W           = 9;
    localparam int META_W         = FILL_W + NODE_W;
    localparam int DATA_W         = 32;
    localparam int MOD_BITS       = 4;
    localparam int MOD_STEPS      = DATA_W / MOD_BITS;
    localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_NEXT  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_ENTRY     = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] key_out;
        logic [DATA_W-1:0] value_out;
        logic              more_entries;
    } rsp_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [BC_W-1:0]   divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [BC_W-1:0]   rem;
    } mod_rsp_t;
endpackage

// File: hw/rtl/bhm_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module bhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/bhm_mod_unit.sv
// Iterative remainder unit: restoring division, a few quotient bits a cycle
`timescale 1ns / 1ps
module bhm_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  bhm_pkg::mod_req_t req,
    output bhm_pkg::mod_rsp_t rsp
);
    logic [bhm_pkg::DATA_W-1:0]    q_reg, q_next;
    logic [bhm_pkg::BC_W-1:0]      r_reg, r_next;
    logic [bhm_pkg::BC_W-1:0]      d_reg, d_next;
    logic [bhm_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    always_comb
    begin
        logic [bhm_pkg::BC_W-1:0] r;
        logic [bhm_pkg::DATA_W-1:0] q;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r = r_reg;
        q = q_reg;
        if (req.start)
        begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so its top bit is free
            for (int i = 0; i < bhm_pkg::MOD_BITS; i++)
            begin
                r = {r[bhm_pkg::BC_W-2:0], q[bhm_pkg::DATA_W-1]};
                q = {q[bhm_pkg::DATA_W-2:0], 1'b0};
                if (r >= d_reg)
                begin
                    r = r - d_reg;
                end
            end
            q_next   = q;
            r_next   = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == bhm_pkg::MOD_CNT_W'(bhm_pkg::MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = r_reg;
endmodule

// File: hw/rtl/bucketed_hash_map_engine_unit.sv
// Top level: bucketed hash map engine with chained overflow nodes
// Add/get: remainder, metadata read per node visited, slot compare per slot, write if adding, then result.
// Iteration start: seeks the first used bucket; next: reads the cursor slot, seeking on at chain end.
// One item at a time; ready only when idle. A finished result waits in the output register.
// Reset (rst_n, async, active low) empties the table, sets 256 buckets and clears the cursor;
// writing bucket_count empties the table without a clearing pass.
`timescale 1ns / 1ps
`include "bucketed_hash_map_engine_unit_assert.svh"
module bucketed_hash_map_engine_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  bhm_pkg::cmd_t              cmd,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output bhm_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [bhm_pkg::BC_W-1:0]   cfg_wdata
);
    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_MOD      = 11'b00000000010,
        S_META     = 11'b00000000100,
        S_META_CHK = 11'b00000001000,
        S_SCAN     = 11'b00000010000,
        S_CMP      = 11'b00000100000,
        S_LINK_WR  = 11'b00001000000,
        S_ITER_RD  = 11'b00010000000,
        S_ITER_OUT = 11'b00100000000,
        S_SEEK     = 11'b01000000000,
        S_RESP     = 11'b10000000000
    } state_t;

    localparam int NODE_W  = bhm_pkg::NODE_W;
    localparam int FILL_W  = bhm_pkg::FILL_W;
    localparam int SLOT_W  = bhm_pkg::SLOT_W;
    localparam int HEAD_W  = bhm_pkg::HEAD_W;
    localparam int BC_W    = bhm_pkg::BC_W;
    localparam int DATA_W  = bhm_pkg::DATA_W;

    state_t                      state_reg, state_next;
    bhm_pkg::cmd_t               cmd_reg, cmd_next;
    logic [NODE_W-1:0]           node_reg, node_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [NODE_W-1:0]           link_reg, link_next;
    logic [FILL_W-1:0]           sidx_reg, sidx_next;
    bhm_pkg::rsp_t               res_reg, res_next;
    bhm_pkg::rsp_t               rsp_reg, rsp_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [BC_W-1:0]             pool_used_reg, pool_used_next;
    logic [bhm_pkg::MAX_BUCKETS-1:0] head_used_reg, head_used_next;
    logic [BC_W-1:0]             bucket_count_reg, bucket_count_next;
    logic                        cur_valid_reg, cur_valid_next;
    logic [NODE_W-1:0]           cur_node_reg, cur_node_next;
    logic [FILL_W-1:0]           cur_slot_reg, cur_slot_next;
    logic [BC_W-1:0]             cur_bucket_reg, cur_bucket_next;
    logic [BC_W-1:0]             seek_b_reg, seek_b_next;

    // node metadata {fill, link}; slot store {key, value}
    logic                           meta_we;
    logic [NODE_W-1:0]              meta_waddr, meta_raddr;
    logic [bhm_pkg::META_W-1:0]     meta_wdata, meta_rdata;
    logic                           slot_we;
    logic [bhm_pkg::SADDR_W-1:0]    slot_waddr, slot_raddr;
    logic [2*DATA_W-1:0]            slot_wdata, slot_rdata;

    bhm_pkg::mod_req_t mod_req;
    bhm_pkg::mod_rsp_t mod_rsp;

    logic [FILL_W-1:0] fill_eff;
    logic [NODE_W-1:0] link_eff;
    logic              head_gone;
    logic [NODE_W-1:0] fresh;
    logic [FILL_W-1:0] slot_inc;

    bhm_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    bhm_ram #(
        .WIDTH (bhm_pkg::META_W),
        .DEPTH (bhm_pkg::NODE_TOTAL)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    bhm_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (bhm_pkg::SLOT_TOTAL)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // A head node not marked used since the last clear reads as empty.
    // Pool nodes are only reached through links written after the clear.
    assign head_gone = !node_reg[NODE_W-1] && !head_used_reg[node_reg[HEAD_W-1:0]];
    assign fill_eff  = head_gone ? '0 : meta_rdata[bhm_pkg::META_W-1:NODE_W];
    assign link_eff  = head_gone ? '0 : meta_rdata[NODE_W-1:0];
    assign fresh     = {1'b1, pool_used_reg[HEAD_W-1:0]};
    assign slot_inc  = cur_slot_reg + 1'b1;

    assign meta_raddr = node_reg;
    assign slot_raddr = (state_reg == S_ITER_RD) ? {node_reg, cur_slot_reg[SLOT_W-1:0]}
                                                 : {node_reg, sidx_reg[SLOT_W-1:0]};

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        node_next         = node_reg;
        fill_next         = fill_reg;
        link_next         = link_reg;
        sidx_next         = sidx_reg;
        res_next          = res_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        pool_used_next    = pool_used_reg;
        head_used_next    = head_used_reg;
        bucket_count_next = bucket_count_reg;
        cur_valid_next    = cur_valid_reg;
        cur_node_next     = cur_node_reg;
        cur_slot_next     = cur_slot_reg;
        cur_bucket_next   = cur_bucket_reg;
        seek_b_next       = seek_b_reg;
        meta_we           = 1'b0;
        meta_waddr        = node_reg;
        meta_wdata        = '0;
        slot_we           = 1'b0;
        slot_waddr        = {node_reg, sidx_reg[SLOT_W-1:0]};
        slot_wdata        = {cmd_reg.key, cmd_reg.value};
        mod_req.start     = 1'b0;
        mod_req.dividend  = cmd.key;
        mod_req.divisor   = bucket_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    unique case (cmd.command)
                        bhm_pkg::CMD_ADD, bhm_pkg::CMD_GET:
                        begin
                            mod_req.start = 1'b1;
                            state_next    = S_MOD;
                        end
                        bhm_pkg::CMD_START:
                        begin
                            seek_b_next = '0;
                            state_next  = S_SEEK;
                        end
                        bhm_pkg::CMD_NEXT:
                        begin
                            if (cur_valid_reg)
                            begin
                                node_next  = cur_node_reg;
                                state_next = S_META;
                            end
                            else
                            begin
                                cur_slot_next   = '0;
                                res_next.status = bhm_pkg::ST_EMPTY;
                                state_next      = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    node_next  = mod_rsp.rem[NODE_W-1:0];
                    state_next = S_META;
                end
            end
            S_META:
            begin
                state_next = S_META_CHK;
            end
            S_META_CHK:
            begin
                fill_next = fill_eff;
                link_next = link_eff;
                sidx_next = '0;
                if (cmd_reg.command == bhm_pkg::CMD_NEXT)
                begin
                    if (cur_slot_reg < fill_eff)
                    begin
                        state_next = S_ITER_RD;
                    end
                    else
                    begin
                        cur_valid_next  = 1'b0;
                        cur_slot_next   = '0;
                        res_next.status = bhm_pkg::ST_EMPTY;
                        state_next      = S_RESP;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (sidx_reg < fill_reg)
                begin
                    state_next = S_CMP;
                end
                else if (link_reg != '0)
                begin
                    node_next  = link_reg;
                    state_next = S_META;
                end
                else if (cmd_reg.command == bhm_pkg::CMD_GET)
                begin
                    res_next.status = bhm_pkg::ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else if (fill_reg < FILL_W'(bhm_pkg::SLOTS_PER_NODE))
                begin
                    // room left in the tail node
                    slot_we    = 1'b1;
                    slot_waddr = {node_reg, fill_reg[SLOT_W-1:0]};
                    meta_we    = 1'b1;
                    meta_wdata = {fill_reg + 1'b1, link_reg};
                    if (!node_reg[NODE_W-1])
                    begin
                        head_used_next[node_reg[HEAD_W-1:0]] = 1'b1;
                    end
                    res_next.status = bhm_pkg::ST_INSERTED;
                    state_next      = S_RESP;
                end
                else if (pool_used_reg < BC_W'(bhm_pkg::POOL_NODES))
                begin
                    // tail full: open a fresh overflow node, link it next cycle
                    slot_we        = 1'b1;
                    slot_waddr     = {fresh, SLOT_W'(0)};
                    meta_we        = 1'b1;
                    meta_waddr     = fresh;
                    meta_wdata     = {FILL_W'(1), NODE_W'(0)};
                    link_next      = fresh;
                    pool_used_next = pool_used_reg + 1'b1;
                    state_next     = S_LINK_WR;
                end
                else
                begin
                    res_next.status = bhm_pkg::ST_FULL;
                    state_next      = S_RESP;
                end
            end
            S_CMP:
            begin
                if (slot_rdata[2*DATA_W-1:DATA_W] == cmd_reg.key)
                begin
                    res_next.value_out = slot_rdata[DATA_W-1:0];
                    if (cmd_reg.command == bhm_pkg::CMD_GET)
                    begin
                        res_next.status = bhm_pkg::ST_FOUND;
                    end
                    else
                    begin
                        slot_we         = 1'b1;
                        res_next.status = bhm_pkg::ST_REPLACED;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_LINK_WR:
            begin
                meta_we         = 1'b1;
                meta_wdata      = {fill_reg, link_reg};
                res_next.status = bhm_pkg::ST_INSERTED;
                state_next      = S_RESP;
            end
            S_ITER_RD:
            begin
                state_next = S_ITER_OUT;
            end
            S_ITER_OUT:
            begin
                res_next.status       = bhm_pkg::ST_ENTRY;
                res_next.key_out      = slot_rdata[2*DATA_W-1:DATA_W];
                res_next.value_out    = slot_rdata[DATA_W-1:0];
                res_next.more_entries = 1'b1;
                if (slot_inc >= fill_reg)
                begin
                    cur_slot_next = '0;
                    if (link_reg != '0)
                    begin
                        cur_node_next = link_reg;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        seek_b_next = cur_bucket_reg;
                        state_next  = S_SEEK;
                    end
                end
                else
                begin
                    cur_slot_next = slot_inc;
                    state_next    = S_RESP;
                end
            end
            S_SEEK:
            begin
                // one bucket a cycle
                priority if (seek_b_reg < bucket_count_reg &&
                             head_used_reg[seek_b_reg[HEAD_W-1:0]])
                begin
                    cur_valid_next        = 1'b1;
                    cur_node_next         = NODE_W'(seek_b_reg);
                    cur_bucket_next       = seek_b_reg + 1'b1;
                    cur_slot_next         = '0;
                    res_next.more_entries = 1'b1;
                    if (cmd_reg.command == bhm_pkg::CMD_START)
                    begin
                        res_next.status = bhm_pkg::ST_ENTRY;
                    end
                    state_next = S_RESP;
                end
                else if (seek_b_reg < bucket_count_reg)
                begin
                    seek_b_next = seek_b_reg + 1'b1;
                end
                else
                begin
                    cur_valid_next        = 1'b0;
                    cur_bucket_next       = bucket_count_reg;
                    cur_slot_next         = '0;
                    res_next.more_entries = 1'b0;
                    if (cmd_reg.command == bhm_pkg::CMD_START)
                    begin
                        res_next.status = bhm_pkg::ST_EMPTY;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // bucket count write: clamp, then empty the table and drop the cursor
        if (cfg_we)
        begin
            priority if (cfg_wdata == '0)
            begin
                bucket_count_next = BC_W'(1);
            end
            else if (cfg_wdata > BC_W'(bhm_pkg::MAX_BUCKETS))
            begin
                bucket_count_next = BC_W'(bhm_pkg::MAX_BUCKETS);
            end
            else
            begin
                bucket_count_next = cfg_wdata;
            end
            head_used_next  = '0;
            pool_used_next  = '0;
            cur_valid_next  = 1'b0;
            cur_node_next   = '0;
            cur_slot_next   = '0;
            cur_bucket_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rsp_valid_reg    <= 1'b0;
            pool_used_reg    <= '0;
            head_used_reg    <= '0;
            bucket_count_reg <= BC_W'(bhm_pkg::MAX_BUCKETS);
            cur_valid_reg    <= 1'b0;
            cur_node_reg     <= '0;
            cur_slot_reg     <= '0;
            cur_bucket_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            pool_used_reg    <= pool_used_next;
            head_used_reg    <= head_used_next;
            bucket_count_reg <= bucket_count_next;
            cur_valid_reg    <= cur_valid_next;
            cur_node_reg     <= cur_node_next;
            cur_slot_reg     <= cur_slot_next;
            cur_bucket_reg   <= cur_bucket_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        node_reg   <= node_next;
        fill_reg   <= fill_next;
        link_reg   <= link_next;
        sidx_reg   <= sidx_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
        seek_b_reg <= seek_b_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // an accepted item keeps the block busy
    `BHM_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
    // the overflow pool never hands out more nodes than it has
    `BHM_ASSERT_NOW(a_pool_bound, 1'b1, pool_used_reg <= BC_W'(bhm_pkg::POOL_NODES))
    // a bucket count write empties the table and the cursor
    `BHM_ASSERT_NEXT(a_cfg_clears, cfg_we, !cur_valid_reg && pool_used_reg == '0)
    // a finished item is loaded into the output register once it is free
    `BHM_ASSERT_NEXT(a_resp_loads, state_reg == S_RESP && (!rsp_valid_reg || rsp_ready),
                     rsp_valid_reg)
endmodule

// File: tb/bucketed_hash_map_engine_unit_checker.sv
// Checker: watches the item channels, predicts each result and compares it
`timescale 1ns / 1ps
module bucketed_hash_map_engine_unit_checker
    import bhm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  cmd_t            cmd,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  rsp_t            rsp,
    input  logic            cfg_we,
    input  logic [BC_W-1:0] cfg_wdata,
    output int              fail_count,
    output int              pending
);
    logic [DATA_W-1:0] map_keys [SLOT_TOTAL];
    logic [DATA_W-1:0] map_vals [SLOT_TOTAL];
    logic [FILL_W-1:0] fill     [NODE_TOTAL];
    logic [NODE_W-1:0] link     [NODE_TOTAL];
    int unsigned       buckets;
    int unsigned       pool_taken;
    int unsigned       walk_bucket;
    int unsigned       walk_node;   // node plus one, zero when none
    int unsigned       walk_slot;
    rsp_t              expected_rsps [$];

    initial fail_count = 0;
    assign pending = expected_rsps.size();

    function automatic void clear_map();
        for (int i = 0; i < NODE_TOTAL; i++)
        begin
            fill[i] = '0;
            link[i] = '0;
        end
        pool_taken  = 0;
        walk_bucket = 0;
        walk_node   = 0;
        walk_slot   = 0;
    endfunction

    function automatic void seek_from(int unsigned from);
        for (int unsigned b = from; b < buckets; b++)
        begin
            if (fill[b] != 0)
            begin
                walk_node   = b + 1;
                walk_bucket = b + 1;
                walk_slot   = 0;
                return;
            end
        end
        walk_node   = 0;
        walk_bucket = buckets;
        walk_slot   = 0;
    endfunction

    // Chain search; slot index or -1, last node of the chain in tail
    function automatic int find_slot(logic [DATA_W-1:0] key, output int unsigned tail);
        int unsigned node;
        node = key % buckets;
        tail = node;
        for (int steps = 0; steps < NODE_TOTAL; steps++)
        begin
            tail = node;
            for (int s = 0; s < fill[node]; s++)
                if (map_keys[node * SLOTS_PER_NODE + s] == key)
                    return node * SLOTS_PER_NODE + s;
            if (link[node] == 0)
                break;
            node = link[node];
        end
        return -1;
    endfunction

    function automatic rsp_t predict_rsp(cmd_t c);
        rsp_t        r;
        int          hit;
        int unsigned tail, idx, fresh, node;
        r = '0;
        r.status = ST_EMPTY;
        case (c.command)
            CMD_ADD, CMD_GET:
            begin
                hit = find_slot(c.key, tail);
                if (c.command == CMD_GET)
                begin
                    r.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
                    if (hit >= 0)
                        r.value_out = map_vals[hit];
                end
                else if (hit >= 0)
                begin
                    r.status    = ST_REPLACED;
                    r.value_out = map_vals[hit];
                    map_vals[hit] = c.value;
                end
                else if (fill[tail] < SLOTS_PER_NODE)
                begin
                    idx = tail * SLOTS_PER_NODE + fill[tail];
                    map_keys[idx] = c.key;
                    map_vals[idx] = c.value;
                    fill[tail]++;
                    r.status = ST_INSERTED;
                end
                else if (pool_taken < POOL_NODES)
                begin
                    fresh = MAX_BUCKETS + pool_taken;
                    pool_taken++;
                    fill[fresh] = 1;
                    link[fresh] = '0;
                    map_keys[fresh * SLOTS_PER_NODE] = c.key;
                    map_vals[fresh * SLOTS_PER_NODE] = c.value;
                    link[tail] = fresh;
                    r.status = ST_INSERTED;
                end
                else
                    r.status = ST_FULL;
            end
            CMD_START:
            begin
                seek_from(0);
                r.more_entries = (walk_node != 0);
                r.status       = r.more_entries ? ST_ENTRY : ST_EMPTY;
            end
            default:
            begin
                node = walk_node - 1;
                if (walk_node != 0 && walk_slot < fill[node])
                begin
                    idx = node * SLOTS_PER_NODE + walk_slot;
                    r.status    = ST_ENTRY;
                    r.key_out   = map_keys[idx];
                    r.value_out = map_vals[idx];
                    walk_slot++;
                    if (walk_slot >= fill[node])
                    begin
                        walk_slot = 0;
                        if (link[node] != 0 && fill[link[node]] != 0)
                            walk_node = link[node] + 1;
                        else
                            seek_from(walk_bucket);
                    end
                    r.more_entries = (walk_node != 0);
                end
                else
                begin
                    walk_node = 0;
                    walk_slot = 0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    initial
    begin
        buckets = MAX_BUCKETS;
        clear_map();
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                buckets = (cfg_wdata == 0) ? 1 :
                          (cfg_wdata > MAX_BUCKETS) ? MAX_BUCKETS : cfg_wdata;
                clear_map();
            end
            if (cmd_valid && cmd_ready)
                expected_rsps.push_back(predict_rsp(cmd));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected item, status", rsp.status, 0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.key_out !== want.key_out)
                        report_mismatch("key_out", rsp.key_out, want.key_out);
                    if (rsp.value_out !== want.value_out)
                        report_mismatch("value_out", rsp.value_out, want.value_out);
                    if (rsp.more_entries !== want.more_entries)
                        report_mismatch("more_entries", rsp.more_entries,
                                        want.more_entries);
                end
            end
        end
    end
endmodule

// File: tb/bucketed_hash_map_engine_unit_tb.sv
// Testbench top: stimulus, idling, long stalls and the verdict for the hash map engine
`timescale 1ns / 1ps
module bucketed_hash_map_engine_unit_tb;
    import bhm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cmd_valid = 1'b0;
    logic            cmd_ready;
    cmd_t            cmd = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    rsp_t            rsp;
    logic            cfg_we = 1'b0;
    logic [BC_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    // idling odds in percent, set per phase
    int tx_idle = 0;
    int rx_idle = 0;
    // long receiver hold: top toggles the request, receiver counts the stretch
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   bucket_setting = MAX_BUCKETS;

    always #4 clk = ~clk;

    bucketed_hash_map_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bucketed_hash_map_engine_unit_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 400;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rx_idle);
    end

    // Offer one item; valid stays up until the item is taken
    task automatic send_item(logic [1:0] op, logic [31:0] key, logic [31:0] value);
        while ($urandom_range(99) < tx_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{command: op, key: key, value: value};
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // Sender pause: lower valid and wait for every outstanding result
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_buckets(logic [BC_W-1:0] count);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bucket_setting = (count == 0) ? 1 : (count > MAX_BUCKETS) ? MAX_BUCKETS : count;
    endtask

    function automatic logic [31:0] pick_key();
        // mostly keys that share buckets, so chains, hits and replaces occur
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(0, 3 * bucket_setting + 8);
    endfunction

    // Mixed traffic: adds and gets, plus iteration walks of random length and single next items
    task automatic random_traffic(int count);
        int sent;
        int pick;
        int walk;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                send_item(CMD_START, $urandom, $urandom);
                walk = $urandom_range(1, 24);
                repeat (walk) send_item(CMD_NEXT, $urandom, $urandom);
                sent += walk + 1;
            end
            else if (pick < 16)
            begin
                send_item(CMD_NEXT, $urandom, $urandom);
                sent++;
            end
            else if (pick < 58)
            begin
                send_item(CMD_ADD, pick_key(), $urandom);
                sent++;
            end
            else
            begin
                send_item(CMD_GET, pick_key(), $urandom);
                sent++;
            end
        end
    endtask

    task automatic idle_phase(int tx, int rx);
        tx_idle = tx;
        rx_idle = rx;
        set_buckets($urandom_range(2, 255));
        random_traffic(65);
        set_buckets(1);
        random_traffic(65);
        set_buckets(9'd256);
        random_traffic(60);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty table, extremes of key and value, replace, iteration
        send_item(CMD_START, '0, '0);
        send_item(CMD_NEXT, '0, '0);
        send_item(CMD_GET, 32'hFFFF_FFFF, '0);
        send_item(CMD_ADD, '0, '0);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
        send_item(CMD_GET, 32'hFFFF_FFFF, '0);
        send_item(CMD_GET, '0, 32'hFFFF_FFFF);
        send_item(CMD_NEXT, '0, '0);
        send_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_NEXT, '0, '0);
        // add behind the cursor mid-walk
        send_item(CMD_ADD, 32'd0 + 9'd256, 32'h1);
        send_item(CMD_ADD, 32'd100, 32'h2);
        repeat (5) send_item(CMD_NEXT, '0, '0);
        // out-of-range counts fold to 1 and to the maximum
        set_buckets(9'd0);
        for (int i = 0; i < 6; i++)
            send_item(CMD_ADD, 32'(i * 7), 32'(i));
        send_item(CMD_START, '0, '0);
        repeat (7) send_item(CMD_NEXT, '0, '0);
        set_buckets(9'd511);
        send_item(CMD_GET, 32'd0, '0);

        // One bucket grows a chain of three nodes: hits in overflow nodes, replace, walk
        set_buckets(9'd256);
        for (int j = 0; j < 2 * SLOTS_PER_NODE + 2; j++)
            send_item(CMD_ADD, 32'(3 + 256 * j), $urandom);
        send_item(CMD_GET, 32'(3 + 256 * (2 * SLOTS_PER_NODE + 1)), '0);
        send_item(CMD_ADD, 32'(3 + 256 * SLOTS_PER_NODE), 32'hCAFE_F00D);
        send_item(CMD_ADD, 32'h0001_0003, 32'hDEAD_BEEF);
        send_item(CMD_START, '0, '0);
        repeat (12) send_item(CMD_NEXT, '0, '0);
        set_buckets(9'd300);

        // Long receiver hold while items keep coming, so the input stalls
        tx_idle = 0;
        rx_idle = 0;
        hold_req <= ~hold_req;
        for (int i = 0; i < 8; i++)
            send_item(CMD_ADD, pick_key(), $urandom);

        idle_phase(25, 76);
        idle_phase(76, 25);
        idle_phase(0, 0);

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
